// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the semaphore table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define CST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds while reset is released.
`define CST_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
// Types and constants of the counting semaphore table.
package cst_pkg;

  localparam int unsigned IndexBits    = 9;
  localparam int unsigned InitBits     = 16;
  localparam int unsigned NumSemsDef   = 512;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_UP    = 2'd2,
    OP_DOWN  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_BLOCK = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } back_state_e;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    op_e                  op;
    logic                 range_err;
    logic                 init_err;
    logic [IndexBits-1:0] index;
    logic [InitBits-1:0]  init;
  } req_t;

endpackage

// ===== rtl/cst_front.sv =====
// Front end: accept requests and classify range and initial count.
module cst_front #(
  parameter int unsigned NUM_SEMS   = cst_pkg::NumSemsDef,
  parameter int unsigned COUNT_BITS = cst_pkg::CountBitsDef
) (
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op_i,
  input  logic [cst_pkg::IndexBits-1:0]  sem_index_i,
  input  logic [cst_pkg::InitBits-1:0]   init_count_i,
  input  logic                           q_full_i,
  input  logic                           clearing_i,
  output logic                           push_o,
  output cst_pkg::req_t                  req_o
);

  localparam longint unsigned CountMax = (64'd1 << COUNT_BITS) - 64'd1;

  assign busy   = q_full_i | clearing_i;
  assign push_o = start & ~busy;

  always_comb begin
    req_o.op        = cst_pkg::op_e'(op_i);
    req_o.range_err = 32'(sem_index_i) >= 32'(NUM_SEMS);
    req_o.init_err  = 64'(init_count_i) > CountMax;
    req_o.index     = sem_index_i;
    req_o.init      = init_count_i;
  end

endmodule

// ===== rtl/cst_queue.sv =====
// Short request queue between front and back.
`include "assert_macros.svh"

module cst_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cst_pkg::req_t req_i,
  input  logic          pop_i,
  output cst_pkg::req_t req_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(cst_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(cst_pkg::QueueDepth + 1);

  cst_pkg::req_t   slot_q [cst_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(cst_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign req_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(cst_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(cst_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= req_i;
    end
  end

  `CST_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i, "queue overflow")
  `CST_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "queue underflow")

endmodule

// ===== rtl/cst_back.sv =====
// Back end: table memory, clearing pass and read-modify-write execution.
`include "assert_macros.svh"

module cst_back #(
  parameter int unsigned NUM_SEMS   = cst_pkg::NumSemsDef,
  parameter int unsigned COUNT_BITS = cst_pkg::CountBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  cst_pkg::req_t q_req_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          done_o,
  output logic [1:0]    status_o,
  output logic          wake_o
);

  localparam int unsigned IdxW = $clog2(NUM_SEMS);
  localparam int unsigned EntW = COUNT_BITS + 1;

  // Entry layout: open flag on top, count below.
  logic [EntW-1:0]         mem [NUM_SEMS];
  logic [EntW-1:0]         rdata_q;
  cst_pkg::req_t           req_q;
  cst_pkg::back_state_e    state_q, state_d;
  logic [IdxW-1:0]         clr_q, clr_d;
  logic                    we;
  logic [IdxW-1:0]         waddr;
  logic [EntW-1:0]         wdata;
  logic                    is_open;
  logic [COUNT_BITS-1:0]   cnt;
  logic                    done_q, done_d;
  cst_pkg::status_e        status_q, status_d;
  logic                    wake_q, wake_d;

  assign is_open    = rdata_q[COUNT_BITS];
  assign cnt        = rdata_q[COUNT_BITS-1:0];
  assign clearing_o = state_q == cst_pkg::BK_CLEAR;
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign wake_o     = wake_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = IdxW'(req_q.index);
    wdata    = '0;
    done_d   = 1'b0;
    status_d = cst_pkg::ST_ERR;
    wake_d   = 1'b0;
    unique case (state_q)
      cst_pkg::BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(NUM_SEMS - 1)) begin
          state_d = cst_pkg::BK_IDLE;
        end
      end
      cst_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = cst_pkg::BK_EXEC;
        end
      end
      cst_pkg::BK_EXEC: begin
        done_d  = 1'b1;
        state_d = cst_pkg::BK_IDLE;
        if (!req_q.range_err) begin
          unique case (req_q.op)
            cst_pkg::OP_OPEN: begin
              if (!is_open && !req_q.init_err) begin
                we       = 1'b1;
                wdata    = {1'b1, COUNT_BITS'(req_q.init)};
                status_d = cst_pkg::ST_OK;
              end
            end
            cst_pkg::OP_CLOSE: begin
              we       = 1'b1;
              wdata    = {1'b0, cnt};
              status_d = cst_pkg::ST_OK;
            end
            cst_pkg::OP_UP: begin
              if (is_open && cnt != '1) begin
                we       = 1'b1;
                wdata    = {1'b1, cnt + 1'b1};
                wake_d   = cnt == '0;
                status_d = cst_pkg::ST_OK;
              end
            end
            cst_pkg::OP_DOWN: begin
              if (is_open) begin
                if (cnt == '0) begin
                  status_d = cst_pkg::ST_BLOCK;
                end else begin
                  we       = 1'b1;
                  wdata    = {1'b1, cnt - 1'b1};
                  status_d = cst_pkg::ST_OK;
                end
              end
            end
            default: begin
              status_d = cst_pkg::ST_ERR;
            end
          endcase
        end
      end
      default: begin
        state_d = cst_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cst_pkg::BK_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= cst_pkg::ST_OK;
      wake_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      status_q <= status_d;
      wake_q   <= wake_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= mem[IdxW'(q_req_i.index)];
      req_q   <= q_req_i;
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  `CST_ASSERT(a_done_after_exec, clk_i, rst_ni,
    done_q |-> $past(state_q == cst_pkg::BK_EXEC), "result without execution")
  `CST_ASSERT(a_exec_after_pop, clk_i, rst_ni,
    state_q == cst_pkg::BK_EXEC |-> $past(pop_o), "execution without a popped item")
  `CST_ASSERT(a_wake_only_ok, clk_i, rst_ni,
    wake_q |-> (done_q && status_q == cst_pkg::ST_OK), "wake on a failed item")

endmodule

// ===== rtl/counting_semaphore_table_unit.sv =====
// Top level of the counting semaphore table.
//
// Usage:
//  - Request channel: drive op_i, sem_index_i and init_count_i with start high.
//    The item is taken at the rising edge where start is high and busy is low.
//    Operations are open, close, up and down on one semaphore of the table.
//  - Result channel: done_o pulses for exactly one cycle with status_o
//    (ok, error, would block) and wake_o. The receiver cannot stall this
//    channel, so results must be captured in the done_o cycle.
//  - Timing: the back end reads the entry when it pops an item in its idle
//    state, then applies the operation, writes back to the single table memory
//    and registers the result in its execute state; it takes no new item before.
//  - A two-entry queue lets the front take items while the back executes;
//    busy rises when that queue is full.
//  - Reset: every semaphore comes up closed. After reset release the back
//    end sweeps the table, one entry per cycle through all NUM_SEMS entries,
//    and busy stays high for that whole pass.
//  - Results come out in acceptance order, exactly one per item.
module counting_semaphore_table_unit #(
  parameter int unsigned NUM_SEMS   = cst_pkg::NumSemsDef,
  parameter int unsigned COUNT_BITS = cst_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic [cst_pkg::IndexBits-1:0] sem_index_i,
  input  logic [cst_pkg::InitBits-1:0]  init_count_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic                          wake_o
);

  // Front to queue
  logic          push;
  cst_pkg::req_t front_req;
  // Queue to back
  cst_pkg::req_t q_req;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  // Back status seen by the front
  logic          clearing;

  // Classify range and initial count, and hold off while queue full or clearing.
  cst_front #(
    .NUM_SEMS   (NUM_SEMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .sem_index_i  (sem_index_i),
    .init_count_i (init_count_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .req_o        (front_req)
  );

  // Buffer classified items so front and back stall independently.
  cst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .pop_i   (pop),
    .req_o   (q_req),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Read the entry, apply the operation, write back and register the result.
  cst_back #(
    .NUM_SEMS   (NUM_SEMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_req_i    (q_req),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .status_o   (status_o),
    .wake_o     (wake_o)
  );

endmodule

// ===== tb/counting_semaphore_table_unit_checker.sv =====
// Checker for the semaphore table: predicts each result and compares it with the block's output.
`timescale 1ns / 100ps

module counting_semaphore_table_unit_checker
  import cst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           op_i,
  input  logic [IndexBits-1:0] sem_index_i,
  input  logic [InitBits-1:0]  init_count_i,
  input  logic                 done_o,
  input  logic [1:0]           status_o,
  input  logic                 wake_o,
  output int                   fail_count,
  output int                   pending,
  output int                   items_taken,
  output int                   wakes_seen,
  output int                   blocks_seen,
  output int                   errors_seen
);

  localparam logic [CountBitsDef-1:0] CountMax = '1;

  typedef struct packed {
    op_e                  op;
    logic [IndexBits-1:0] index;
    status_e              status;
    logic                 wake;
  } sem_outcome_t;

  // Shadow copy of the table; the index field never exceeds the table.
  logic [CountBitsDef-1:0] shadow_count [NumSemsDef];
  logic                    shadow_open  [NumSemsDef];

  sem_outcome_t outcome_q [$];
  sem_outcome_t oldest;
  int n_fail, n_taken, n_wake, n_block, n_err;

  function automatic sem_outcome_t apply_request(op_e op, logic [IndexBits-1:0] idx,
                                                 logic [InitBits-1:0] init);
    sem_outcome_t res;
    res.op     = op;
    res.index  = idx;
    res.status = ST_ERR;
    res.wake   = 1'b0;
    case (op)
      OP_OPEN: begin
        if (!shadow_open[idx]) begin
          shadow_count[idx] = init;
          shadow_open[idx]  = 1'b1;
          res.status        = ST_OK;
        end
      end
      OP_CLOSE: begin
        shadow_open[idx] = 1'b0;
        res.status       = ST_OK;
      end
      OP_UP: begin
        if (shadow_open[idx] && shadow_count[idx] != CountMax) begin
          res.wake          = (shadow_count[idx] == '0);
          shadow_count[idx] = shadow_count[idx] + 1'b1;
          res.status        = ST_OK;
        end
      end
      default: begin
        if (shadow_open[idx]) begin
          if (shadow_count[idx] == '0) begin
            res.status = ST_BLOCK;
          end else begin
            shadow_count[idx] = shadow_count[idx] - 1'b1;
            res.status        = ST_OK;
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_open[i]) shadow_open[i] = 1'b0;
      outcome_q.delete();
      n_fail  = 0;
      n_taken = 0;
      n_wake  = 0;
      n_block = 0;
      n_err   = 0;
    end else begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: status %0d wake %0b",
                   $time, status_o, wake_o);
          n_fail++;
        end else begin
          oldest = outcome_q.pop_front();
          if (status_o !== oldest.status) begin
            $display("%0t: %s on %0d: status expected %0d, actual %0d", $time,
                     oldest.op.name(), oldest.index, oldest.status, status_o);
            n_fail++;
          end
          if (wake_o !== oldest.wake) begin
            $display("%0t: %s on %0d: wake expected %0b, actual %0b", $time,
                     oldest.op.name(), oldest.index, oldest.wake, wake_o);
            n_fail++;
          end
          if (oldest.wake) n_wake++;
          if (oldest.status == ST_BLOCK) n_block++;
          if (oldest.status == ST_ERR) n_err++;
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(apply_request(op_e'(op_i), sem_index_i, init_count_i));
        n_taken++;
      end
    end
    fail_count  <= n_fail;
    pending     <= outcome_q.size();
    items_taken <= n_taken;
    wakes_seen  <= n_wake;
    blocks_seen <= n_block;
    errors_seen <= n_err;
  end

endmodule

// ===== tb/counting_semaphore_table_unit_tb.sv =====
// Testbench top for the semaphore table: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module counting_semaphore_table_unit_tb;
  import cst_pkg::*;

  localparam int unsigned NumItems   = 1600;
  localparam int unsigned CycleLimit = 400000;  // clearing pass plus gaps, many times over
  localparam int unsigned PoolSize   = 12;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 start        = 1'b0;
  logic [1:0]           op_i         = OP_OPEN;
  logic [IndexBits-1:0] sem_index_i  = '0;
  logic [InitBits-1:0]  init_count_i = '0;
  logic                 busy;
  logic                 done_o;
  logic [1:0]           status_o;
  logic                 wake_o;

  int fail_count, pending, items_taken, wakes_seen, blocks_seen, errors_seen;
  int unsigned cycles = 0;

  // Most random traffic lands on a few hot entries so that sequences build up
  // state; slots 0 and 1 pin the table's first and last entries.
  logic [IndexBits-1:0] index_pool [PoolSize];

  counting_semaphore_table_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .sem_index_i  (sem_index_i),
    .init_count_i (init_count_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .wake_o       (wake_o)
  );

  counting_semaphore_table_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .sem_index_i  (sem_index_i),
    .init_count_i (init_count_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .wake_o       (wake_o),
    .fail_count   (fail_count),
    .pending      (pending),
    .items_taken  (items_taken),
    .wakes_seen   (wakes_seen),
    .blocks_seen  (blocks_seen),
    .errors_seen  (errors_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending);
      $display("[counting_semaphore_table_unit] ERROR");
      $finish;
    end
  end

  // Present one item and hold it until the edge that takes it. Start stays high
  // on return so that back-to-back items need no second assignment.
  task automatic issue(input op_e op, input logic [IndexBits-1:0] idx,
                       input logic [InitBits-1:0] cnt);
    start        <= 1'b1;
    op_i         <= op;
    sem_index_i  <= idx;
    init_count_i <= cnt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start and idle for a number of cycles.
  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random request: mostly hot entries and small counts, with counts near the
  // top of the range so that up runs into the ceiling, and some full noise.
  task automatic issue_random();
    int unsigned          pick;
    op_e                  op;
    logic [IndexBits-1:0] idx;
    logic [InitBits-1:0]  cnt;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) begin
      idx = index_pool[$urandom_range(0, PoolSize - 1)];
    end else begin
      idx = IndexBits'($urandom_range(0, NumSemsDef - 1));
    end
    case ($urandom_range(0, 4))
      0, 1, 2: cnt = InitBits'($urandom_range(0, 3));
      3:       cnt = InitBits'($urandom_range(65532, 65535));
      default: cnt = InitBits'($urandom);
    endcase
    if (pick < 10) begin
      op = OP_OPEN;
    end else if (pick < 16) begin
      op = OP_CLOSE;
    end else if (pick < 58) begin
      op = OP_UP;
    end else begin
      op = OP_DOWN;
    end
    issue(op, idx, cnt);
  endtask

  initial begin
    int unsigned burst_left;
    index_pool[0] = '0;
    index_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      index_pool[i] = IndexBits'($urandom_range(0, NumSemsDef - 1));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: operations on closed entries, already open, down at zero,
    // wake on up from zero, up at the ceiling, close when already closed.
    issue(OP_UP,    9'd0,   16'h1234);
    issue(OP_DOWN,  9'd0,   16'hFFFF);
    issue(OP_CLOSE, 9'd511, 16'h0000);
    issue(OP_OPEN,  9'd0,   16'h0000);
    issue(OP_OPEN,  9'd0,   16'h0005);
    issue(OP_DOWN,  9'd0,   16'h0000);
    issue(OP_UP,    9'd0,   16'h0000);
    issue(OP_UP,    9'd0,   16'h0000);
    issue(OP_DOWN,  9'd0,   16'h0000);
    issue(OP_OPEN,  9'd511, 16'hFFFF);
    issue(OP_UP,    9'd511, 16'h0000);
    issue(OP_DOWN,  9'd511, 16'h0000);
    issue(OP_UP,    9'd511, 16'h0000);
    issue(OP_UP,    9'd511, 16'h0000);
    issue(OP_OPEN,  9'h155, 16'hAAAA);
    issue(OP_OPEN,  9'h0AA, 16'h5555);
    issue(OP_DOWN,  9'h155, 16'h0000);
    issue(OP_UP,    9'h0AA, 16'h0000);
    issue(OP_CLOSE, 9'd0,   16'h0000);
    issue(OP_UP,    9'd0,   16'h0000);
    issue(OP_DOWN,  9'd0,   16'h0000);
    issue(OP_CLOSE, 9'd0,   16'h0000);
    settle();

    // Random: bursts of random length, some without gaps between them.
    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < NumItems; n++) begin
      if (n == NumItems / 2) settle();
      if (n % 200 == 0) index_pool[$urandom_range(2, PoolSize - 1)] =
          IndexBits'($urandom_range(0, NumSemsDef - 1));
      issue_random();
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 40);
      end
    end

    settle();
    hold_off(12);
    $display("Run covered %0d requests: %0d wake-ups, %0d would-block, %0d refused.",
             items_taken, wakes_seen, blocks_seen, errors_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[counting_semaphore_table_unit] OK");
    end else begin
      $display("[counting_semaphore_table_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_queue.sv
rtl/cst_back.sv
rtl/counting_semaphore_table_unit.sv
tb/counting_semaphore_table_unit_checker.sv
tb/counting_semaphore_table_unit_tb.sv
